@@ rtl/npc_pkg.sv @@
// Shared types and helpers for the nearest palette color search.
// Holds the stage record that travels down the cell chain and the distance function.
package npc_pkg;

    localparam int COMP_W  = 8;
    localparam int INDEX_W = 8;
    localparam int DIST_W  = 18;
    localparam int COLOR_W = 3 * COMP_W;

    localparam logic             OP_WRITE   = 1'b0;
    localparam logic             OP_PIXEL   = 1'b1;
    localparam logic [DIST_W-1:0] DIST_START = {DIST_W{1'b1}};

    typedef struct packed {
        logic               valid;
        logic               write;
        logic [INDEX_W-1:0] entry_index;
        logic [COMP_W-1:0]  red;
        logic [COMP_W-1:0]  green;
        logic [COMP_W-1:0]  blue;
        logic               clear;
        logic [DIST_W-1:0]  best_dist;
        logic [INDEX_W-1:0] best_index;
        logic [DIST_W-1:0]  pend_dist;
    } t_stage;

    function automatic logic [2*COMP_W-1:0] comp_sq(
        input logic [COMP_W-1:0] a,
        input logic [COMP_W-1:0] b
    );
        logic [COMP_W-1:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return d * d;
    endfunction

    function automatic logic [DIST_W-1:0] npc_dist(
        input logic [COMP_W-1:0]  r,
        input logic [COMP_W-1:0]  g,
        input logic [COMP_W-1:0]  b,
        input logic [COLOR_W-1:0] entry
    );
        logic [DIST_W-1:0] sr;
        logic [DIST_W-1:0] sg;
        logic [DIST_W-1:0] sb;
        sr = DIST_W'(comp_sq(r, entry[3*COMP_W-1:2*COMP_W]));
        sg = DIST_W'(comp_sq(g, entry[2*COMP_W-1:COMP_W]));
        sb = DIST_W'(comp_sq(b, entry[COMP_W-1:0]));
        return sr + sg + sb;
    endfunction

endpackage

@@ rtl/npc_cell.sv @@
// One search cell: holds one palette entry, measures the passing pixel against it
// and folds the previous cell's distance into the running best. Uses npc_pkg.
module npc_cell #(
    parameter int CELL_INDEX = 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_adv,
    input  npc_pkg::t_stage i_prev,
    output npc_pkg::t_stage o_stage
);
    import npc_pkg::*;

    localparam logic [INDEX_W-1:0] ENTRY_IDX = INDEX_W'(CELL_INDEX);
    localparam logic [INDEX_W-1:0] PEND_IDX  = INDEX_W'(CELL_INDEX - 1);
    localparam bit                 PEND_LIVE = (CELL_INDEX > 1);

    logic [COLOR_W-1:0] r_entry;
    t_stage             r_stage;
    t_stage             n_stage;

    always_comb begin
        n_stage = i_prev;
        n_stage.pend_dist = npc_dist(i_prev.red, i_prev.green, i_prev.blue, r_entry);
        if (PEND_LIVE && (i_prev.pend_dist < i_prev.best_dist)) begin
            n_stage.best_dist  = i_prev.pend_dist;
            n_stage.best_index = PEND_IDX;
        end
    end

    // entry has no reset: contents undefined until written
    always_ff @(posedge i_clk) begin
        if (i_adv && i_prev.valid && i_prev.write && (i_prev.entry_index == ENTRY_IDX)) begin
            r_entry <= {i_prev.red, i_prev.green, i_prev.blue};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else if (i_adv) begin
            r_stage <= n_stage;
        end
    end

    assign o_stage = r_stage;

endmodule

@@ rtl/nearest_palette_color.sv @@
// Nearest palette color search over a chain of cells, one per entry 1..PALETTE_ENTRIES-1.
// Uses npc_pkg and npc_cell.
//
// Write requests (operation 0) store one RGB palette entry; pixel requests (operation 1)
// return the lowest index among entries 1..PALETTE_ENTRIES-1 with the smallest squared RGB
// distance, or index 0 and distance 0 when alpha is 0. One request is taken per clock while
// o_ready is high. The depth is set by an input register, the chain of one distance cell per
// entry 1..PALETTE_ENTRIES-1, each with its own entry register, and an output register. Writes
// travel down the chain in order, so a pixel sees exactly the writes taken before it. A stalled
// result stalls the whole chain.
module nearest_palette_color #(
    parameter int PALETTE_ENTRIES = 256
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic                        i_operation,
    input  logic [npc_pkg::INDEX_W-1:0] i_entry_index,
    input  logic [npc_pkg::COMP_W-1:0]  i_red,
    input  logic [npc_pkg::COMP_W-1:0]  i_green,
    input  logic [npc_pkg::COMP_W-1:0]  i_blue,
    input  logic [npc_pkg::COMP_W-1:0]  i_alpha,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [npc_pkg::INDEX_W-1:0] o_color_index,
    output logic [npc_pkg::DIST_W-1:0]  o_best_distance
);
    import npc_pkg::*;

    localparam logic [INDEX_W-1:0] LAST_IDX = INDEX_W'(PALETTE_ENTRIES - 1);

    logic               w_adv;
    t_stage             r_s0;
    t_stage             w_stage [PALETTE_ENTRIES];
    t_stage             w_last;
    logic               r_out_valid;
    logic [INDEX_W-1:0] r_out_index;
    logic [DIST_W-1:0]  r_out_dist;
    logic               n_out_valid;
    logic [INDEX_W-1:0] n_out_index;
    logic [DIST_W-1:0]  n_out_dist;

    assign w_adv   = !r_out_valid || i_ready;
    assign o_ready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0.valid <= 1'b0;
        end else if (w_adv) begin
            r_s0.valid       <= i_valid;
            r_s0.write       <= (i_operation == OP_WRITE);
            r_s0.entry_index <= i_entry_index;
            r_s0.red         <= i_red;
            r_s0.green       <= i_green;
            r_s0.blue        <= i_blue;
            r_s0.clear       <= (i_alpha == '0);
            r_s0.best_dist   <= DIST_START;
            r_s0.best_index  <= '0;
            r_s0.pend_dist   <= '0;
        end
    end

    assign w_stage[0] = r_s0;

    for (genvar k = 1; k < PALETTE_ENTRIES; k++) begin : g_cell
        npc_cell #(
            .CELL_INDEX(k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_prev  (w_stage[k-1]),
            .o_stage (w_stage[k])
        );
    end

    assign w_last = w_stage[PALETTE_ENTRIES-1];

    always_comb begin
        n_out_valid = w_last.valid && !w_last.write;
        if (w_last.pend_dist < w_last.best_dist) begin
            n_out_index = LAST_IDX;
            n_out_dist  = w_last.pend_dist;
        end else begin
            n_out_index = w_last.best_index;
            n_out_dist  = w_last.best_dist;
        end
        if (w_last.clear) begin
            n_out_index = '0;
            n_out_dist  = '0;
        end else if (n_out_index == '0) begin
            n_out_dist = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= n_out_valid;
            r_out_index <= n_out_index;
            r_out_dist  <= n_out_dist;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_color_index   = r_out_index;
    assign o_best_distance = r_out_dist;

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_index_zero_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_color_index == '0)) |-> (o_best_distance == '0))
        else $error("index 0 with nonzero distance");

    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_color_index <= LAST_IDX))
        else $error("index beyond palette");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=>
            (o_valid && $stable(o_color_index) && $stable(o_best_distance)))
        else $error("chain advanced under a stalled result");

endmodule
